[hdl/phe_pkg.sv]
`default_nettype none

package phe_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int DEG_W     = 4;
  localparam int Q_W       = 32;
  localparam int PROD_W    = 2 * Q_W;

  localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] Q_MIN = -PROD_W'(64'sd2147483648);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [3:0]            coefficient_index;
    logic signed [Q_W-1:0] coefficient_value;
    logic signed [Q_W-1:0] x_value;
  } in_word_t;

  typedef struct packed {
    logic signed [Q_W-1:0] poly_value;
    logic                  saturated;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic init;
    logic mul;
    logic add;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deg_zero;
    logic idx_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/phe_datapath.sv]
`default_nettype none

module phe_datapath
  import phe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_word_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [DEG_W-1:0] cfg_wdata,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  output out_word_t             result
);

  logic [DEG_W-1:0]            degree_r;
  logic signed [Q_W-1:0]       store_r [MAX_TERMS];
  logic signed [Q_W-1:0]       x_r;
  logic signed [Q_W-1:0]       p_r;
  logic signed [Q_W-1:0]       coef_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [IDX_W-1:0]            idx_r;
  logic                        sat_r;

  logic [IDX_W-1:0]            n_clamped;
  logic [IDX_W-1:0]            idx_m1;
  logic [IDX_W-1:0]            load_idx;
  logic                        load_ok;
  logic signed [PROD_W-1:0]    sum;
  logic signed [Q_W-1:0]       p_nxt;
  logic                        clip_hit;

  always_comb begin
    if (int'(degree_r) > MAX_TERMS - 1) begin
      n_clamped = IDX_W'(MAX_TERMS - 1);
    end else begin
      n_clamped = IDX_W'(degree_r);
    end
  end

  assign idx_m1   = idx_r - IDX_W'(1);
  assign load_idx = IDX_W'(in_data.coefficient_index);
  assign load_ok  = int'(in_data.coefficient_index) < MAX_TERMS;

  // floor(p*x / 2^F) + a, clipped once to the Q range
  always_comb begin
    sum      = (prod_r >>> FRAC_BITS) + PROD_W'(coef_r);
    clip_hit = 1'b1;
    priority if (sum > Q_MAX) begin
      p_nxt = Q_MAX[Q_W-1:0];
    end else if (sum < Q_MIN) begin
      p_nxt = Q_MIN[Q_W-1:0];
    end else begin
      p_nxt    = sum[Q_W-1:0];
      clip_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int i = 0; i < MAX_TERMS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
      if (cmd.load && load_ok) begin
        store_r[load_idx] <= in_data.coefficient_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.init) begin
      sat_r <= 1'b0;
    end else if (cmd.add && clip_hit) begin
      sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r   <= in_data.x_value;
      p_r   <= store_r[n_clamped];
      idx_r <= n_clamped;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(p_r) * PROD_W'(x_r);
      coef_r <= store_r[idx_m1];
    end
    if (cmd.add) begin
      p_r   <= p_nxt;
      idx_r <= idx_m1;
    end
  end

  assign sts.deg_zero = (n_clamped == '0);
  assign sts.idx_last = (idx_r == IDX_W'(1));

  assign result.poly_value = p_r;
  assign result.saturated  = sat_r;

endmodule

`default_nettype wire

[hdl/phe_ctrl.sv]
`default_nettype none

module phe_ctrl
  import phe_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    opcode,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         busy,
  output logic         out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign accept   = start && (state_r == S_IDLE);
  assign cmd.load = accept && (opcode == OP_LOAD);
  assign cmd.init = accept && (opcode == OP_EVAL);
  assign cmd.mul  = (state_r == S_MUL);
  assign cmd.add  = (state_r == S_ADD);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start && (opcode == OP_EVAL)) begin
            // degree zero: a_0 is already in the accumulator
            if (sts.deg_zero) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (sts.idx_last) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_MUL;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/polynomial_horner_evaluator.sv]
// channel   ports                          word / handshake
// input     start, busy, in_data           in_word_t, taken when start && !busy
// result    out_valid, out_data            out_word_t, valid for one cycle
// config    cfg_we, cfg_wdata              degree, written when cfg_we
//
// A load word is taken in one cycle; busy stays low.
// An evaluate word of degree n keeps busy high for 2n cycles in the shared 32x32
// multiplier and adder (one multiply cycle, one add/clip cycle per term); out_valid
// rises 2n cycles after the accepting edge (at once for degree 0), the result is
// taken at the edge after that, and the next word may be taken in that same cycle.
// Reset (synchronous, rst_n low) clears the coefficients to zero and degree to 0.
// The receiver cannot stall: each result is shown exactly once.
`default_nettype none

module polynomial_horner_evaluator
  import phe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [DEG_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  phe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_data.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  phe_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .result    (out_data)
  );

endmodule

`default_nettype wire

[hdl/phe_checker.sv]
`default_nettype none

module phe_checker
  import phe_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire in_word_t         in_data,
  input wire logic             out_valid,
  input wire out_word_t        out_data,
  input wire logic             cfg_we,
  input wire logic [DEG_W-1:0] cfg_wdata
);

  // busy only starts from an accepted evaluate word
  a_busy_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy && (in_data.opcode == OP_EVAL)))
    else $error("busy rose without an accepted evaluate word");

  // a result always ends a busy period
  a_fall_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && (in_data.opcode == OP_EVAL))))
    else $error("result without a pending evaluate word");

  // the user changes the degree only while no evaluation is running; the block does not enforce it
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (!busy && !$isunknown(cfg_wdata) && !$isunknown(out_data.saturated)
                || !busy))
    else $error("degree written while busy");

endmodule

bind polynomial_horner_evaluator phe_checker u_phe_checker (.*);

`default_nettype wire

[tb/tb_polynomial_horner_evaluator.sv]
`timescale 1ns / 1ps

module tb_polynomial_horner_evaluator;
  import phe_pkg::*;

  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 160;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_word_t        in_data;
  logic            out_valid;
  out_word_t       out_data;
  logic            cfg_we;
  logic [DEG_W-1:0] cfg_wdata;

  int stall_cycles;
  int phase_degrees [9] = '{0, 15, 1, 2, 4, 7, 11, 15, 3};

  polynomial_horner_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the coefficient store and degree, plus the queue of pending values.
  class poly_checker;
    logic signed [Q_W-1:0] coeff_mirror [MAX_TERMS];
    logic [DEG_W-1:0]      degree_mirror;
    out_word_t             pending_values [$];
    int                    errors;
    int                    loads;
    int                    evals;
    int                    clipped;

    function new();
      foreach (coeff_mirror[i]) coeff_mirror[i] = '0;
      degree_mirror = '0;
      errors = 0;
      loads = 0;
      evals = 0;
      clipped = 0;
    endfunction

    function void set_degree(logic [DEG_W-1:0] d);
      degree_mirror = d;
    endfunction

    function int outstanding();
      return pending_values.size();
    endfunction

    // Horner's rule: exact 64-bit product, floor shift, exact sum, clip per step.
    function out_word_t horner_value(logic signed [Q_W-1:0] x);
      out_word_t r;
      longint    acc;
      longint    prod;
      int        n;
      bit        clip_seen;
      n = int'(degree_mirror);
      if (n > MAX_TERMS - 1) n = MAX_TERMS - 1;
      acc = longint'(coeff_mirror[n]);
      clip_seen = 1'b0;
      for (int i = n; i > 0; i--) begin
        prod = (acc * longint'(x)) >>> FRAC_BITS;
        acc = prod + longint'(coeff_mirror[i-1]);
        if (acc > Q_MAX) begin
          acc = Q_MAX;
          clip_seen = 1'b1;
        end else if (acc < Q_MIN) begin
          acc = Q_MIN;
          clip_seen = 1'b1;
        end
      end
      r.poly_value = acc[Q_W-1:0];
      r.saturated = clip_seen;
      return r;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      if (w.opcode == OP_LOAD) begin
        loads++;
        if (int'(w.coefficient_index) < MAX_TERMS)
          coeff_mirror[w.coefficient_index] = w.coefficient_value;
      end else begin
        evals++;
        r = horner_value(w.x_value);
        if (r.saturated) clipped++;
        pending_values.push_back(r);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected result word value=%h sat=%b",
                         got.poly_value, got.saturated));
      end else begin
        want = pending_values.pop_front();
        if (got.poly_value !== want.poly_value)
          report($sformatf("poly_value got %h want %h", got.poly_value, want.poly_value));
        if (got.saturated !== want.saturated)
          report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      end
    endtask
  endclass

  poly_checker scoreboard = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) scoreboard.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic signed [Q_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      8: begin
        if ($urandom_range(0, 1)) return 32'sh0001_0000 + $signed($urandom_range(0, 4095)) - 2048;
        return 32'shffff_0000 + $signed($urandom_range(0, 4095)) - 2048;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic in_word_t mk_load(logic [3:0] idx, logic signed [Q_W-1:0] val);
    in_word_t w;
    w.opcode = OP_LOAD;
    w.coefficient_index = idx;
    w.coefficient_value = val;
    w.x_value = $urandom;
    return w;
  endfunction

  function automatic in_word_t mk_eval(logic signed [Q_W-1:0] x);
    in_word_t w;
    w.opcode = OP_EVAL;
    w.coefficient_index = 4'($urandom_range(0, 15));
    w.coefficient_value = $urandom;
    w.x_value = x;
    return w;
  endfunction

  // Returns at the edge that takes the word; start is left high for the caller.
  task automatic send_word(in_word_t w);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    scoreboard.note_word(w);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      start <= 1'b0;
      do @(posedge clk); while (scoreboard.outstanding() != 0);
    end else if (r >= 60) begin
      n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_degree(logic [DEG_W-1:0] d);
    start <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    scoreboard.set_degree(d);
  endtask

  initial begin
    bit no_idle;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degree zero with a cleared store, then a_0 alone
    send_word(mk_eval(32'sh7fff_ffff));
    send_word(mk_load(4'd0, 32'sh7fff_ffff));
    send_word(mk_eval(32'sh8000_0000));

    // degree one: negative clip, plain sum, floor rounding of a tiny negative product
    write_degree(4'd1);
    send_word(mk_load(4'd1, 32'sh0001_0000));
    send_word(mk_load(4'd0, 32'sh8000_0000));
    send_word(mk_eval(32'shffff_0000));
    send_word(mk_eval(32'sh0001_0000));
    send_word(mk_load(4'd1, -32'sd1));
    send_word(mk_load(4'd0, 32'sh0000_0000));
    send_word(mk_eval(32'sd1));
    send_word(mk_eval(32'sh8000_0000));

    // full degree: untouched entries still read as zero, positive clip
    write_degree(4'd15);
    send_word(mk_eval(32'sh0002_0000));
    send_word(mk_load(4'd15, 32'sh7fff_ffff));
    send_word(mk_load(4'd14, 32'sh0000_0000));
    send_word(mk_eval(32'sh7fff_ffff));
    send_word(mk_eval(32'sh0000_0000));
    send_word(mk_eval(32'sh8000_0000));
    send_word(mk_load(4'd0, 32'sh0003_0000));
    send_word(mk_eval(-32'sd1));

    foreach (phase_degrees[p]) begin
      write_degree(DEG_W'(phase_degrees[p]));
      no_idle = (p % 2 == 1);
      for (int i = 0; i <= phase_degrees[p]; i++) begin
        send_word(mk_load(4'(i), rand_q()));
        if (!no_idle) idle_gap();
      end
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 35)
          send_word(mk_load(4'($urandom_range(0, 15)), rand_q()));
        else
          send_word(mk_eval(rand_q()));
        if (!no_idle) idle_gap();
      end
    end

    start <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d coefficient loads and %0d evaluations over %0d degree settings,",
             scoreboard.loads, scoreboard.evals, $size(phase_degrees) + 3);
    $display("with %0d clipped results and %0d mismatches.",
             scoreboard.clipped, scoreboard.errors);
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/phe_pkg.sv
hdl/phe_datapath.sv
hdl/phe_ctrl.sv
hdl/polynomial_horner_evaluator.sv
hdl/phe_checker.sv
tb/tb_polynomial_horner_evaluator.sv
